// ----- sv/pdsr_pkg.sv -----
// ----------------------------------------------------------------------------
// pdsr_pkg
// Shared widths, command and register codes, and payload types for the
// PWM duty slew ramp.
// ----------------------------------------------------------------------------
`default_nettype none

package pdsr_pkg;

    localparam int unsigned DUTY_W     = 14;
    localparam int unsigned CMP_W      = 16;
    localparam int unsigned RELOAD_W   = 16;
    localparam int unsigned CMD_W      = 2;
    localparam int unsigned STEP_CNT_W = 7;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam int unsigned MAX_RAMP_STEPS_DEF = 100;

    localparam logic [DUTY_W-1:0] FULL_SCALE = 14'd10000;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_SET  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RELOAD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_START = 2'd2;

    // Register reset values
    localparam logic [RELOAD_W-1:0] RELOAD_RST    = 16'd1000;
    localparam logic [DUTY_W-1:0]   STEP_RST      = 14'd100;
    localparam logic [DUTY_W-1:0]   MIN_START_RST = 14'd0;

    // Divide by 10000: drop 4 bits (divide by 16), then divide by 625 through
    // a reciprocal multiply that may come out one low, then correct.
    localparam int unsigned PROD_W      = RELOAD_W + DUTY_W;   // 30
    localparam int unsigned PRE_SHIFT   = 4;
    localparam int unsigned X_W         = PROD_W - PRE_SHIFT;  // 26
    localparam int unsigned RECIP_W     = 27;
    localparam int unsigned RECIP_SHIFT = 36;
    localparam int unsigned Q_W         = X_W + RECIP_W - RECIP_SHIFT; // 17
    localparam int unsigned BASE_W      = 10;
    localparam int unsigned QM_W        = Q_W + BASE_W;        // 27
    localparam logic [RECIP_W-1:0] RECIP_625 = 27'd109951162;  // floor(2^36/625)
    localparam logic [BASE_W-1:0]  DIV_BASE  = 10'd625;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              wrote;
        logic              busy;
    } t_item;

    typedef struct packed {
        logic [CMP_W-1:0]  compare;
        logic              wrote;
        logic [DUTY_W-1:0] duty;
        logic              busy;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/pdsr_if.sv -----
// ----------------------------------------------------------------------------
// pdsr_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdsr_in_if;
    import pdsr_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [DUTY_W-1:0] target_percent;

    modport source (output valid, output cmd, output target_percent, input ready);
    modport sink   (input valid, input cmd, input target_percent, output ready);
endinterface

interface pdsr_out_if;
    import pdsr_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMP_W-1:0]  compare_value;
    logic              compare_write;
    logic [DUTY_W-1:0] duty_now;
    logic              ramp_busy;

    modport source (output valid, output compare_value, output compare_write,
                    output duty_now, output ramp_busy, input ready);
    modport sink   (input valid, input compare_value, input compare_write,
                    input duty_now, input ramp_busy, output ready);
endinterface

`default_nettype wire

// ----- sv/pdsr_scale.sv -----
// ----------------------------------------------------------------------------
// pdsr_scale
// Three-stage pipeline turning a duty into compare = reload * duty / 10000.
// ----------------------------------------------------------------------------
`default_nettype none

module pdsr_scale (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [pdsr_pkg::RELOAD_W-1:0]    i_reload,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  pdsr_pkg::t_item                  i_item,
    output logic                             o_valid,
    input  logic                             i_ready,
    output pdsr_pkg::t_result                o_result
);
    import pdsr_pkg::*;

    // Stage A: product
    logic              r_a_v;
    t_item             r_a_item;
    logic [PROD_W-1:0] r_a_prod;
    // Stage B: quotient estimate
    logic              r_b_v;
    t_item             r_b_item;
    logic [X_W-1:0]    r_b_x;
    logic [Q_W-1:0]    r_b_q;
    // Stage C: result
    logic              r_c_v;
    t_result           r_c_res;

    logic w_a_rdy, w_b_rdy, w_c_rdy;
    logic [X_W-1:0]             w_x;
    logic [X_W+RECIP_W-1:0]     w_xm;
    logic [QM_W-1:0]            w_qm;
    logic [QM_W-1:0]            w_rem;
    logic [Q_W-1:0]             w_q;

    assign w_c_rdy = !r_c_v || i_ready;
    assign w_b_rdy = !r_b_v || w_c_rdy;
    assign w_a_rdy = !r_a_v || w_b_rdy;
    assign o_ready = w_a_rdy;

    assign w_x   = r_a_prod[PROD_W-1:PRE_SHIFT];
    assign w_xm  = (X_W+RECIP_W)'(w_x) * (X_W+RECIP_W)'(RECIP_625);
    assign w_qm  = QM_W'(r_b_q) * QM_W'(DIV_BASE);
    assign w_rem = QM_W'(r_b_x) - w_qm;
    // estimate runs at most one low
    assign w_q   = (w_rem >= QM_W'(DIV_BASE)) ? r_b_q + 1'b1 : r_b_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (w_a_rdy) begin
                r_a_v <= i_valid;
            end
            if (w_b_rdy) begin
                r_b_v <= r_a_v;
            end
            if (w_c_rdy) begin
                r_c_v <= r_b_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_rdy) begin
            r_a_item <= i_item;
            r_a_prod <= PROD_W'(i_reload) * PROD_W'(i_item.duty);
        end
        if (w_b_rdy) begin
            r_b_item <= r_a_item;
            r_b_x    <= w_x;
            r_b_q    <= w_xm[X_W+RECIP_W-1:RECIP_SHIFT];
        end
        if (w_c_rdy) begin
            r_c_res.compare <= w_q[CMP_W-1:0];
            r_c_res.wrote   <= r_b_item.wrote;
            r_c_res.duty    <= r_b_item.duty;
            r_c_res.busy    <= r_b_item.busy;
        end
    end

    assign o_valid  = r_c_v;
    assign o_result = r_c_res;

endmodule

`default_nettype wire

// ----- sv/pwm_duty_slew_ramp.sv -----
// ----------------------------------------------------------------------------
// pwm_duty_slew_ramp
// Soft-start duty ramp for one PWM channel with compare value output.
// ----------------------------------------------------------------------------
//
//  channel   dir   payload                                        handshake
//  i_in      in    cmd, target_percent                             valid/ready
//  o_out     out   compare_value, compare_write, duty_now, busy    valid/ready
//  cfg       in    i_cfg_idx, i_cfg_data                           i_cfg_we
//
//  One word is taken every cycle while i_in.ready is high. The ramp state and
//  the ramp result register at the edge that accepts the word; the compare
//  value then goes through a product stage, a reciprocal-multiply stage and a
//  correction stage, each registered, before the result shows on o_out. The
//  three multiplies of the scaling sit in these stages.
//  Reset is synchronous, active low: duty, goal and step count clear and the
//  registers return to reload 1000, step 100, min start 0.
//  Each pipeline stage holds when the one after it is full and stalled;
//  i_in.ready drops only once every stage holds a word.
//
`default_nettype none

module pwm_duty_slew_ramp #(
    parameter int unsigned MAX_RAMP_STEPS = pdsr_pkg::MAX_RAMP_STEPS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pdsr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pdsr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    pdsr_in_if.sink                            i_in,
    pdsr_out_if.source                         o_out
);
    import pdsr_pkg::*;

    localparam logic [STEP_CNT_W-1:0] STEP_LIMIT = STEP_CNT_W'(MAX_RAMP_STEPS);

    // Configuration registers
    logic [RELOAD_W-1:0] r_reload;
    logic [DUTY_W-1:0]   r_step;
    logic [DUTY_W-1:0]   r_min_start;

    // Ramp state
    logic [DUTY_W-1:0]     r_cur_duty,    n_cur_duty;
    logic [DUTY_W-1:0]     r_goal,        n_goal;
    logic                  r_going_up,    n_going_up;
    logic                  r_ramp_active, n_ramp_active;
    logic [STEP_CNT_W-1:0] r_steps,       n_steps;
    logic                  n_wrote;

    // Stage between the ramp logic and the scaler
    logic  r_s_v;
    t_item r_s_item;
    t_item n_item;

    logic w_acc, w_s_rdy, w_scale_rdy;
    logic [DUTY_W-1:0] w_target, w_min_sat, w_gap_up, w_gap_dn, w_next;
    logic [STEP_CNT_W-1:0] w_steps_inc;
    t_result w_res;

    assign w_s_rdy    = !r_s_v || w_scale_rdy;
    assign i_in.ready = w_s_rdy;
    assign w_acc      = i_in.valid && w_s_rdy;

    // Clamp requests above full scale
    assign w_target  = (i_in.target_percent > FULL_SCALE) ? FULL_SCALE : i_in.target_percent;
    assign w_min_sat = (r_min_start > FULL_SCALE) ? FULL_SCALE : r_min_start;
    assign w_gap_up  = r_goal - r_cur_duty;
    assign w_gap_dn  = r_cur_duty - r_goal;
    assign w_steps_inc = r_steps + 1'b1;

    // Next duty for one tick; a step that would pass the goal lands on it
    always_comb begin
        if (r_steps == '0 && r_cur_duty == '0) begin
            w_next = (w_min_sat > r_goal) ? r_goal : w_min_sat;
        end else if (r_going_up) begin
            w_next = (r_goal > r_cur_duty && r_step < w_gap_up) ? r_cur_duty + r_step : r_goal;
        end else begin
            w_next = (r_cur_duty > r_goal && r_step < w_gap_dn) ? r_cur_duty - r_step : r_goal;
        end
    end

    always_comb begin
        n_cur_duty    = r_cur_duty;
        n_goal        = r_goal;
        n_going_up    = r_going_up;
        n_ramp_active = r_ramp_active;
        n_steps       = r_steps;
        n_wrote       = 1'b0;
        case (i_in.cmd)
            CMD_SET: begin
                // arm only when idle and the goal actually moves the duty
                if (!r_ramp_active && w_target != r_cur_duty) begin
                    n_goal        = w_target;
                    n_going_up    = w_target > r_cur_duty;
                    n_steps       = '0;
                    n_ramp_active = 1'b1;
                end
            end
            CMD_TICK: begin
                if (r_ramp_active) begin
                    n_cur_duty = w_next;
                    n_steps    = w_steps_inc;
                    n_wrote    = 1'b1;
                    // end on reaching the goal or at the step limit
                    if (w_next == r_goal || w_steps_inc >= STEP_LIMIT) begin
                        n_ramp_active = 1'b0;
                        n_steps       = '0;
                    end
                end
            end
            CMD_STOP: begin
                n_cur_duty    = '0;
                n_goal        = '0;
                n_going_up    = 1'b0;
                n_ramp_active = 1'b0;
                n_steps       = '0;
                n_wrote       = 1'b1;
            end
            default: begin
            end
        endcase
        n_item.duty  = n_cur_duty;
        n_item.wrote = n_wrote;
        n_item.busy  = n_ramp_active;
    end

    // Configuration writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload    <= RELOAD_RST;
            r_step      <= STEP_RST;
            r_min_start <= MIN_START_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RELOAD:    r_reload    <= i_cfg_data[RELOAD_W-1:0];
                CFG_STEP:      r_step      <= i_cfg_data[DUTY_W-1:0];
                CFG_MIN_START: r_min_start <= i_cfg_data[DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Advance ramp state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_duty    <= '0;
            r_goal        <= '0;
            r_going_up    <= 1'b0;
            r_ramp_active <= 1'b0;
            r_steps       <= '0;
            r_s_v         <= 1'b0;
        end else begin
            if (w_acc) begin
                r_cur_duty    <= n_cur_duty;
                r_goal        <= n_goal;
                r_going_up    <= n_going_up;
                r_ramp_active <= n_ramp_active;
                r_steps       <= n_steps;
            end
            if (w_s_rdy) begin
                r_s_v <= w_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_rdy) begin
            r_s_item <= n_item;
        end
    end

    pdsr_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_reload (r_reload),
        .i_valid  (r_s_v),
        .o_ready  (w_scale_rdy),
        .i_item   (r_s_item),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_result (w_res)
    );

    assign o_out.compare_value = w_res.compare;
    assign o_out.compare_write = w_res.wrote;
    assign o_out.duty_now      = w_res.duty;
    assign o_out.ramp_busy     = w_res.busy;

    // Duty never leaves the full-scale range
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_duty <= FULL_SCALE)
        else $error("duty above full scale");

    // An idle ramp keeps no step count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ramp_active |-> r_steps == '0)
        else $error("step count left over after ramp end");

    // A running ramp has not yet reached its goal
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ramp_active |-> r_cur_duty != r_goal)
        else $error("ramp active at goal");

    // Stop clears duty and ends the ramp
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in.cmd == CMD_STOP) |=> (r_cur_duty == '0 && !r_ramp_active))
        else $error("stop did not clear the ramp");

endmodule

`default_nettype wire
